// ----- sv/itoa_pkg.sv -----
// Shared types, codes and the control program of the integer to ASCII formatter.
package itoa_pkg;

  typedef struct packed {
    logic [3:0]  cmd;
    logic [31:0] value;
  } item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last;
  } text_t;

  localparam logic [3:0] CMD_HEX8  = 4'd0;
  localparam logic [3:0] CMD_HEX16 = 4'd1;
  localparam logic [3:0] CMD_HEX32 = 4'd2;
  localparam logic [3:0] CMD_S8    = 4'd3;
  localparam logic [3:0] CMD_U8    = 4'd4;
  localparam logic [3:0] CMD_S16   = 4'd5;
  localparam logic [3:0] CMD_U16   = 4'd6;
  localparam logic [3:0] CMD_S32   = 4'd7;
  localparam logic [3:0] CMD_U32   = 4'd8;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam int UPC_W = 4;

  localparam logic [2:0] OP_NOP      = 3'd0;
  localparam logic [2:0] OP_LOAD     = 3'd1;
  localparam logic [2:0] OP_DABBLE   = 3'd2;
  localparam logic [2:0] OP_SET_DIG  = 3'd3;
  localparam logic [2:0] OP_MINUS    = 3'd4;
  localparam logic [2:0] OP_SKIP     = 3'd5;
  localparam logic [2:0] OP_EMIT_DEC = 3'd6;
  localparam logic [2:0] OP_EMIT_HEX = 3'd7;

  localparam logic [2:0] C_NEVER      = 3'd0;
  localparam logic [2:0] C_ALWAYS     = 3'd1;
  localparam logic [2:0] C_NOT_ACCEPT = 3'd2;
  localparam logic [2:0] C_BAD        = 3'd3;
  localparam logic [2:0] C_HEX        = 3'd4;
  localparam logic [2:0] C_CNT_NZ     = 3'd5;
  localparam logic [2:0] C_NOT_NEG    = 3'd6;
  localparam logic [2:0] C_SKIP_MORE  = 3'd7;

  localparam logic [UPC_W-1:0] STEP_IDLE     = 4'd0;
  localparam logic [UPC_W-1:0] STEP_DISPATCH = 4'd1;
  localparam logic [UPC_W-1:0] STEP_KIND     = 4'd2;
  localparam logic [UPC_W-1:0] STEP_DABBLE   = 4'd3;
  localparam logic [UPC_W-1:0] STEP_SET_DIG  = 4'd4;
  localparam logic [UPC_W-1:0] STEP_MINUS    = 4'd5;
  localparam logic [UPC_W-1:0] STEP_SKIP     = 4'd6;
  localparam logic [UPC_W-1:0] STEP_EMIT_DEC = 4'd7;
  localparam logic [UPC_W-1:0] STEP_DEC_DONE = 4'd8;
  localparam logic [UPC_W-1:0] STEP_EMIT_HEX = 4'd9;
  localparam logic [UPC_W-1:0] STEP_HEX_DONE = 4'd10;

  typedef struct packed {
    logic [2:0]       op;
    logic [2:0]       cond;
    logic [UPC_W-1:0] target;
  } ctrl_word_t;

  typedef struct packed {
    logic [2:0] op;
    logic       en;
  } ctrl_t;

  typedef struct packed {
    logic is_hex;
    logic bad;
    logic neg;
    logic cnt_nz;
    logic skip_more;
    logic out_busy;
  } status_t;

  function automatic ctrl_word_t program_rom(logic [UPC_W-1:0] addr);
    ctrl_word_t w;
    case (addr)
      STEP_IDLE:     w = '{OP_LOAD,     C_NOT_ACCEPT, STEP_IDLE};
      STEP_DISPATCH: w = '{OP_NOP,      C_BAD,        STEP_IDLE};
      STEP_KIND:     w = '{OP_NOP,      C_HEX,        STEP_EMIT_HEX};
      STEP_DABBLE:   w = '{OP_DABBLE,   C_CNT_NZ,     STEP_DABBLE};
      STEP_SET_DIG:  w = '{OP_SET_DIG,  C_NOT_NEG,    STEP_SKIP};
      STEP_MINUS:    w = '{OP_MINUS,    C_NEVER,      STEP_IDLE};
      STEP_SKIP:     w = '{OP_SKIP,     C_SKIP_MORE,  STEP_SKIP};
      STEP_EMIT_DEC: w = '{OP_EMIT_DEC, C_CNT_NZ,     STEP_EMIT_DEC};
      STEP_DEC_DONE: w = '{OP_NOP,      C_ALWAYS,     STEP_IDLE};
      STEP_EMIT_HEX: w = '{OP_EMIT_HEX, C_CNT_NZ,     STEP_EMIT_HEX};
      STEP_HEX_DONE: w = '{OP_NOP,      C_ALWAYS,     STEP_IDLE};
      default:       w = '{OP_NOP,      C_ALWAYS,     STEP_IDLE};
    endcase
    return w;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = CH_ZERO + {4'd0, nib};
    end else begin
      c = CH_A + {4'd0, nib} - 8'd10;
    end
    return c;
  endfunction

endpackage

// ----- sv/itoa_seq.sv -----
// Microcode sequencer: step counter, program table and jump condition logic.
module itoa_seq (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  itoa_pkg::status_t      status,
  output itoa_pkg::ctrl_t        ctrl
);

  logic [itoa_pkg::UPC_W-1:0] upc;
  logic [itoa_pkg::UPC_W-1:0] upc_next;
  itoa_pkg::ctrl_word_t       word;
  logic                       accept;
  logic                       is_emit;
  logic                       stall;
  logic                       take;

  assign word       = itoa_pkg::program_rom(upc);
  assign item_ready = (upc == itoa_pkg::STEP_IDLE);
  assign accept     = item_ready && item_valid;
  assign is_emit    = (word.op == itoa_pkg::OP_MINUS) || (word.op == itoa_pkg::OP_EMIT_DEC) ||
                      (word.op == itoa_pkg::OP_EMIT_HEX);
  assign stall      = is_emit && status.out_busy;

  always_comb begin
    case (word.cond)
      itoa_pkg::C_NEVER:      take = 1'b0;
      itoa_pkg::C_ALWAYS:     take = 1'b1;
      itoa_pkg::C_NOT_ACCEPT: take = !accept;
      itoa_pkg::C_BAD:        take = status.bad;
      itoa_pkg::C_HEX:        take = status.is_hex;
      itoa_pkg::C_CNT_NZ:     take = status.cnt_nz;
      itoa_pkg::C_NOT_NEG:    take = !status.neg;
      itoa_pkg::C_SKIP_MORE:  take = status.skip_more;
      default:                take = 1'b1;
    endcase
  end

  always_comb begin
    if (stall) begin
      upc_next = upc;
    end else if (take) begin
      upc_next = word.target;
    end else begin
      upc_next = upc + 1'b1;
    end
  end

  assign ctrl.op = word.op;
  assign ctrl.en = !stall && ((word.op != itoa_pkg::OP_LOAD) || accept);

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= itoa_pkg::STEP_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

// ----- sv/itoa_dp.sv -----
// Datapath: magnitude shifter, BCD accumulator, digit counter and output register.
module itoa_dp (
  input  logic              clk,
  input  logic              rst,
  input  itoa_pkg::item_t   item,
  input  itoa_pkg::ctrl_t   ctrl,
  output itoa_pkg::status_t status,
  output logic              text_valid,
  input  logic              text_ready,
  output itoa_pkg::text_t   text
);

  logic [3:0]  cmd_r;
  logic        neg;
  logic [31:0] sh;
  logic [39:0] bcd;
  logic [4:0]  cnt;

  logic [31:0] ext;
  logic        sgn;
  logic        ld_hex;
  logic [31:0] ld_sh;
  logic [4:0]  ld_cnt;
  logic [39:0] bcd_adj;

  always_comb begin
    ext = item.value;
    sgn = 1'b0;
    case (item.cmd)
      itoa_pkg::CMD_S8: begin
        ext = {{24{item.value[7]}}, item.value[7:0]};
        sgn = item.value[7];
      end
      itoa_pkg::CMD_U8:  ext = {24'd0, item.value[7:0]};
      itoa_pkg::CMD_S16: begin
        ext = {{16{item.value[15]}}, item.value[15:0]};
        sgn = item.value[15];
      end
      itoa_pkg::CMD_U16: ext = {16'd0, item.value[15:0]};
      itoa_pkg::CMD_S32: sgn = item.value[31];
      default:           ext = item.value;
    endcase
  end

  always_comb begin
    ld_hex = (item.cmd <= itoa_pkg::CMD_HEX32);
    case (item.cmd)
      itoa_pkg::CMD_HEX8: begin
        ld_sh  = {item.value[7:0], 24'd0};
        ld_cnt = 5'd1;
      end
      itoa_pkg::CMD_HEX16: begin
        ld_sh  = {item.value[15:0], 16'd0};
        ld_cnt = 5'd3;
      end
      itoa_pkg::CMD_HEX32: begin
        ld_sh  = item.value;
        ld_cnt = 5'd7;
      end
      default: begin
        ld_sh  = sgn ? (32'd0 - ext) : ext;
        ld_cnt = 5'd31;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < 10; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  assign status.is_hex    = (cmd_r <= itoa_pkg::CMD_HEX32);
  assign status.bad       = (cmd_r > itoa_pkg::CMD_U32);
  assign status.neg       = neg;
  assign status.cnt_nz    = (cnt != 5'd0);
  assign status.skip_more = (bcd[39:36] == 4'd0) && (cnt != 5'd0);
  assign status.out_busy  = text_valid && !text_ready;

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      case (ctrl.op)
        itoa_pkg::OP_LOAD: begin
          cmd_r <= item.cmd;
          neg   <= sgn && !ld_hex;
          sh    <= ld_sh;
          cnt   <= ld_cnt;
          bcd   <= 40'd0;
        end
        itoa_pkg::OP_DABBLE: begin
          bcd <= {bcd_adj[38:0], sh[31]};
          sh  <= {sh[30:0], 1'b0};
          cnt <= cnt - 5'd1;
        end
        itoa_pkg::OP_SET_DIG: cnt <= 5'd9;
        itoa_pkg::OP_SKIP: begin
          if (status.skip_more) begin
            bcd <= {bcd[35:0], 4'd0};
            cnt <= cnt - 5'd1;
          end
        end
        itoa_pkg::OP_EMIT_DEC: begin
          text.out_char <= itoa_pkg::CH_ZERO + {4'd0, bcd[39:36]};
          text.last     <= (cnt == 5'd0);
          bcd           <= {bcd[35:0], 4'd0};
          cnt           <= cnt - 5'd1;
        end
        itoa_pkg::OP_EMIT_HEX: begin
          text.out_char <= itoa_pkg::hex_char(sh[31:28]);
          text.last     <= (cnt == 5'd0);
          sh            <= {sh[27:0], 4'd0};
          cnt           <= cnt - 5'd1;
        end
        itoa_pkg::OP_MINUS: begin
          text.out_char <= itoa_pkg::CH_MINUS;
          text.last     <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_valid <= 1'b0;
    end else if (ctrl.en && ((ctrl.op == itoa_pkg::OP_MINUS) ||
                             (ctrl.op == itoa_pkg::OP_EMIT_DEC) ||
                             (ctrl.op == itoa_pkg::OP_EMIT_HEX))) begin
      text_valid <= 1'b1;
    end else if (text_ready) begin
      text_valid <= 1'b0;
    end
  end

endmodule

// ----- sv/integer_to_ascii_formatter.sv -----
// Top level of the integer to ASCII formatter.
// Each accepted item is turned into its ASCII text, one character per output beat, most
// significant first, with last set on the final character; an unknown format code gives no
// beats and sends the program straight back to idle. The block works on one item at a time
// under a small microcode program. A hex item emits two, four or eight digits. A decimal
// item runs the shift-and-add-3 loop that forms its BCD digits, writes a minus sign if it
// is negative, suppresses its leading zeros and then emits its digits. A stalled output
// beat holds the program on its emitting step.
module integer_to_ascii_formatter (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  itoa_pkg::item_t   item,
  output logic              text_valid,
  input  logic              text_ready,
  output itoa_pkg::text_t   text
);

  itoa_pkg::status_t status;
  itoa_pkg::ctrl_t   ctrl;

  itoa_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .status     (status),
    .ctrl       (ctrl)
  );

  itoa_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .ctrl       (ctrl),
    .status     (status),
    .text_valid (text_valid),
    .text_ready (text_ready),
    .text       (text)
  );

endmodule

// ----- sv/itoa_checker.sv -----
// Port-level checks of the integer to ASCII formatter and their binding.
module itoa_checker (
  input logic            clk,
  input logic            rst,
  input logic            item_valid,
  input logic            item_ready,
  input itoa_pkg::item_t item,
  input logic            text_valid,
  input logic            text_ready,
  input itoa_pkg::text_t text
);

  a_item_hold: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_ready |=> item_valid && $stable(item))
    else $error("Input beat changed while waiting.");

  a_text_hold: assert property (@(posedge clk) disable iff (rst)
    text_valid && !text_ready |=> text_valid && $stable(text))
    else $error("Output beat changed while stalled.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("Input ready stayed high after an item was taken.");

  a_no_item_mid_text: assert property (@(posedge clk) disable iff (rst)
    text_valid && !text.last |-> !item_ready)
    else $error("Input ready high while a number is still being sent.");

  a_char_set: assert property (@(posedge clk) disable iff (rst)
    text_valid |-> (text.out_char == itoa_pkg::CH_MINUS) ||
                   ((text.out_char >= itoa_pkg::CH_ZERO) &&
                    (text.out_char <= itoa_pkg::CH_NINE)) ||
                   ((text.out_char >= itoa_pkg::CH_A) &&
                    (text.out_char <= itoa_pkg::CH_F)))
    else $error("Output character outside the digit set.");

endmodule

bind integer_to_ascii_formatter itoa_checker u_itoa_checker (
  .clk        (clk),
  .rst        (rst),
  .item_valid (item_valid),
  .item_ready (item_ready),
  .item       (item),
  .text_valid (text_valid),
  .text_ready (text_ready),
  .text       (text)
);

// ----- test/tb.sv -----
// Self-checking testbench of the integer to ASCII formatter with its own model of the text.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STUCK_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 100;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            item_valid = 1'b0;
  logic            item_ready;
  itoa_pkg::item_t item = '0;
  logic            text_valid;
  logic            text_ready = 1'b0;
  itoa_pkg::text_t text;

  itoa_pkg::text_t expected_chars[$];
  int    char_errors = 0;
  int    stuck_cycles = 0;
  bit    no_idle = 1'b0;
  bit    hold_off_pending = 1'b0;

  integer_to_ascii_formatter dut (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .text_valid (text_valid),
    .text_ready (text_ready),
    .text       (text)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void format_number(input itoa_pkg::item_t it);
    logic [7:0]      chars[$];
    logic [31:0]     mag;
    logic [3:0]      nib;
    bit              neg;
    int              ndig;
    itoa_pkg::text_t t;
    neg = 1'b0;
    ndig = 0;
    mag = 32'd0;
    case (it.cmd)
      itoa_pkg::CMD_HEX8:  ndig = 2;
      itoa_pkg::CMD_HEX16: ndig = 4;
      itoa_pkg::CMD_HEX32: ndig = 8;
      itoa_pkg::CMD_S8: begin
        mag = {24'd0, it.value[7:0]};
        if (it.value[7]) begin
          neg = 1'b1;
          mag = 32'h100 - mag;
        end
      end
      itoa_pkg::CMD_U8:  mag = {24'd0, it.value[7:0]};
      itoa_pkg::CMD_S16: begin
        mag = {16'd0, it.value[15:0]};
        if (it.value[15]) begin
          neg = 1'b1;
          mag = 32'h10000 - mag;
        end
      end
      itoa_pkg::CMD_U16: mag = {16'd0, it.value[15:0]};
      itoa_pkg::CMD_S32: begin
        mag = it.value;
        if (it.value[31]) begin
          neg = 1'b1;
          mag = 32'd0 - it.value;
        end
      end
      itoa_pkg::CMD_U32: mag = it.value;
      default: return;
    endcase
    if (ndig > 0) begin
      for (int i = ndig - 1; i >= 0; i--) begin
        nib = it.value[i*4 +: 4];
        chars.push_back(nib < 4'd10 ? itoa_pkg::CH_ZERO + 8'(nib)
                                    : itoa_pkg::CH_A + 8'(nib) - 8'd10);
      end
    end else begin
      do begin
        chars.push_front(itoa_pkg::CH_ZERO + 8'(mag % 32'd10));
        mag = mag / 32'd10;
      end while (mag != 32'd0);
      if (neg) begin
        chars.push_front(itoa_pkg::CH_MINUS);
      end
    end
    foreach (chars[i]) begin
      t.out_char = chars[i];
      t.last = (i == chars.size() - 1);
      expected_chars.push_back(t);
    end
  endfunction

  function automatic itoa_pkg::item_t random_item();
    itoa_pkg::item_t it;
    logic [31:0]     p;
    int              k;
    if ($urandom_range(99) < 5) begin
      it.cmd = 4'($urandom_range(15, 9));
    end else begin
      it.cmd = 4'($urandom_range(8));
    end
    case ($urandom_range(9))
      5: it.value = $urandom_range(20);
      6: begin
        k = $urandom_range(2);
        it.value = (32'd1 << (k == 2 ? 31 : 7 + 8 * k)) - 32'($urandom_range(1));
      end
      7: begin
        p = 32'd1;
        repeat ($urandom_range(9)) p = p * 32'd10;
        it.value = p + 32'($urandom_range(2)) - 32'd1;
      end
      8: it.value = $urandom >> $urandom_range(31);
      9: it.value = 32'd0 - 32'($urandom_range(20, 1));
      default: it.value = $urandom;
    endcase
    return it;
  endfunction

  task automatic send_item(input itoa_pkg::item_t it);
    while (!no_idle && $urandom_range(99) < 8) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    format_number(it);
  endtask

  task automatic release_items();
    item_valid <= 1'b0;
  endtask

  task automatic wait_text_drained();
    do @(posedge clk); while (expected_chars.size() != 0);
  endtask

  task automatic send_random_items(input int count);
    itoa_pkg::item_t it;
    int              sent;
    sent = 0;
    while (sent < count) begin
      it = random_item();
      send_item(it);
      if (it.cmd <= itoa_pkg::CMD_U32) begin
        sent++;
      end
    end
  endtask

  task automatic test_hex_formats();
    send_item({itoa_pkg::CMD_HEX8, 32'h0000_0000});
    send_item({itoa_pkg::CMD_HEX8, 32'h1234_56FF});
    send_item({itoa_pkg::CMD_HEX16, 32'hFFFF_0000});
    send_item({itoa_pkg::CMD_HEX32, 32'h0000_0000});
    send_item({itoa_pkg::CMD_HEX32, 32'hFFFF_FFFF});
    send_item({itoa_pkg::CMD_HEX32, 32'h89AB_CDEF});
  endtask

  task automatic test_decimal_formats();
    send_item({itoa_pkg::CMD_S8, 32'h0000_0080});
    send_item({itoa_pkg::CMD_S8, 32'h0000_007F});
    send_item({itoa_pkg::CMD_S8, 32'hFFFF_FFFF});
    send_item({itoa_pkg::CMD_U8, 32'h0000_00FF});
    send_item({itoa_pkg::CMD_U8, 32'hFFFF_FF00});
    send_item({itoa_pkg::CMD_S16, 32'h0000_8000});
    send_item({itoa_pkg::CMD_S16, 32'h0000_7FFF});
    send_item({itoa_pkg::CMD_S16, 32'hFFFF_0000});
    send_item({itoa_pkg::CMD_U16, 32'h0000_FFFF});
    send_item({itoa_pkg::CMD_S32, 32'h8000_0000});
    send_item({itoa_pkg::CMD_S32, 32'h7FFF_FFFF});
    send_item({itoa_pkg::CMD_S32, 32'h0000_0000});
    send_item({itoa_pkg::CMD_U32, 32'hFFFF_FFFF});
    send_item({itoa_pkg::CMD_U32, 32'h0000_000A});
  endtask

  task automatic test_unknown_formats();
    send_item({4'd9, 32'h0000_0000});
    send_item({4'd15, 32'hFFFF_FFFF});
    send_item({itoa_pkg::CMD_U8, 32'h0000_0007});
  endtask

  task automatic test_back_to_back();
    no_idle = 1'b1;
    send_random_items(60);
    no_idle = 1'b0;
  endtask

  task automatic test_output_hold_off();
    hold_off_pending = 1'b1;
    send_random_items(25);
  endtask

  task automatic test_input_pause();
    send_random_items(8);
    release_items();
    wait_text_drained();
    send_random_items(8);
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        text_ready <= 1'b0;
        repeat (HOLD_CYCLES) begin
          @(posedge clk);
          text_ready <= 1'b0;
        end
      end else begin
        text_ready <= no_idle || ($urandom_range(99) >= 8);
      end
    end
  end

  always @(posedge clk) begin : check_text
    itoa_pkg::text_t want;
    if (!rst && text_valid && text_ready) begin
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got char %h last %b",
                 $time, text.out_char, text.last);
        char_errors++;
      end else begin
        want = expected_chars.pop_front();
        if (text.out_char !== want.out_char) begin
          $display("%0t: out_char expected %h got %h", $time, want.out_char, text.out_char);
          char_errors++;
        end
        if (text.last !== want.last) begin
          $display("%0t: last expected %b got %b", $time, want.last, text.last);
          char_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((item_valid && item_ready) || (text_valid && text_ready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_hex_formats();
    test_decimal_formats();
    test_unknown_formats();
    test_back_to_back();
    send_random_items(200);
    test_output_hold_off();
    test_input_pause();
    release_items();
    wait_text_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (char_errors == 0 && expected_chars.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
